// File: rtl/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
// No dependencies; used by matrix_multiply.
package mm_pkg;

  // Default store dimension and the cap the 3-bit row and column fields allow.
  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_CAP     = 8;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 36;
  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_START  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  // A zero dimension counts as one; anything above the limit counts as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = DIM_W'(1);
    end else if (r > lim) begin
      res = lim;
    end
    return res;
  endfunction

endpackage

// File: rtl/matrix_multiply.sv
// Matrix multiply top level: element stores for A and B, a shared
// multiply-accumulate unit under a small sequencer, and an output register.
// Depends on mm_pkg.

// Load items (func 0 for A, 1 for B) write one signed Q8.8 element each. A
// start item (func 2) emits the product A x B in row-major order as signed
// Q20.16 values, with last_element set on the final one. The single
// multiplier and the registered store reads set the pace: each product term
// goes through read, multiply and accumulate steps, and each element then
// waits in an output step, longer if the output is stalled. When the
// effective a_cols differs from b_rows every element is zero with dim_error
// set and comes straight from the output step. The block stalls its input
// for the whole product. Elements must be loaded before they are used; the
// stores are not cleared at reset.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0]        cfg_data_i,
  // Input items.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      func_i,
  input  logic [mm_pkg::IDX_W-1:0]        row_index_i,
  input  logic [mm_pkg::IDX_W-1:0]        col_index_i,
  input  logic signed [mm_pkg::ELEM_W-1:0] element_value_i,
  // Result items.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mm_pkg::IDX_W-1:0]        out_row_o,
  output logic [mm_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [mm_pkg::ACC_W-1:0] product_value_o,
  output logic                            last_element_o,
  output logic                            dim_error_o
);
  import mm_pkg::*;

  localparam int LIM   = (MAX_DIM < DIM_CAP) ? MAX_DIM : DIM_CAP;
  localparam int DEPTH = LIM * LIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (LIM > 1) ? $clog2(LIM) : 1;
  localparam logic [DIM_W-1:0] LIM_DIM = DIM_W'(LIM);

  // Configuration registers.
  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DIM_W-1:0] ar_eff, ac_eff, br_eff, bc_eff;

  // Element stores.
  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;

  // Sequencer and datapath.
  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic err_q, err_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [IDX_W-1:0]         out_row_q, out_row_d, out_col_q, out_col_d;
  logic signed [ACC_W-1:0]  out_val_q, out_val_d;
  logic                     out_last_q, out_last_d, out_err_q, out_err_d;
  logic                     out_load;

  logic in_acc, load_a, load_b, ld_in_range;
  logic [AW-1:0] ld_addr, rd_addr_a, rd_addr_b;
  logic last_i, last_j, last_k;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(8);
      a_cols_q <= DIM_W'(8);
      b_rows_q <= DIM_W'(8);
      b_cols_q <= DIM_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ar_eff = eff_dim(a_rows_q, LIM_DIM);
  assign ac_eff = eff_dim(a_cols_q, LIM_DIM);
  assign br_eff = eff_dim(b_rows_q, LIM_DIM);
  assign bc_eff = eff_dim(b_cols_q, LIM_DIM);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Loads outside the LIM x LIM store are dropped.
  assign ld_in_range = (DIM_W'(row_index_i) < LIM_DIM) && (DIM_W'(col_index_i) < LIM_DIM);
  assign load_a  = in_acc && (func_i == FUNC_LOAD_A) && ld_in_range;
  assign load_b  = in_acc && (func_i == FUNC_LOAD_B) && ld_in_range;
  assign ld_addr = AW'(CW'(row_index_i)) * AW'(LIM) + AW'(CW'(col_index_i));

  assign rd_addr_a = AW'(i_q) * AW'(LIM) + AW'(k_q);
  assign rd_addr_b = AW'(k_q) * AW'(LIM) + AW'(j_q);

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      mem_a[ld_addr] <= element_value_i;
    end
    a_rd_q <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      mem_b[ld_addr] <= element_value_i;
    end
    b_rd_q <= mem_b[rd_addr_b];
  end

  assign last_i = (DIM_W'(i_q) + DIM_W'(1)) == ar_eff;
  assign last_j = (DIM_W'(j_q) + DIM_W'(1)) == bc_eff;
  assign last_k = (DIM_W'(k_q) + DIM_W'(1)) == ac_eff;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    err_d   = err_q;
    prod_d  = prod_q;
    acc_d   = acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (func_i == FUNC_START)) begin
          i_d   = '0;
          j_d   = '0;
          k_d   = '0;
          acc_d = '0;
          err_d = (ac_eff != br_eff);
          state_d = (ac_eff != br_eff) ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = a_rd_q * b_rd_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        if (last_k) begin
          state_d = ST_OUT;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          acc_d = '0;
          k_d   = '0;
          if (last_j) begin
            j_d = '0;
            i_d = i_q + CW'(1);
          end else begin
            j_d = j_q + CW'(1);
          end
          if (last_i && last_j) begin
            state_d = ST_IDLE;
          end else if (!err_q) begin
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_row_d   = IDX_W'(i_q);
      out_col_d   = IDX_W'(j_q);
      out_val_d   = acc_q;
      out_last_d  = last_i && last_j;
      out_err_d   = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_val_q;
  assign last_element_o  = out_last_q;
  assign dim_error_o     = out_err_q;

endmodule
